// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle forces a condition in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== design/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

	localparam int LEN_W     = 63;
	localparam int ACC_W     = 64;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int QCNT_W    = 3;
	localparam int TDATA_W   = 80;

	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;
	localparam logic [3:0] EXT_BYTES16 = 4'd2;
	localparam logic [3:0] EXT_BYTES64 = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// One classified result, passed from the parser to the output side.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         raw;     // byte as received
		logic [7:0]         key;     // key byte to XOR in
		logic [7:0]         hdr0;    // first header byte
		logic               masked;
		logic [LEN_W-1:0]   length;
		logic               last;
	} entry_t;

	// Queue status seen by the parser.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== design/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
//
// Channel  Dir  Fields (low bit up)                                  Transfer
// s_*      in   tdata: raw stream byte [7:0]                         tvalid & tready
// m_*      out  tdata: data_byte, opcode, fin, rsv1, rsv2, rsv3,     tvalid & tready
//               masked, frame_len; tuser: kind; tlast: frame_end
//
// One input byte is taken per cycle while the queue is not full; each byte is
// fully classified in the cycle it is taken, so the parser loop is the only
// feedback path. A result reaches m_tdata through the queue write and then the
// output register. The 4-entry queue absorbs output stalls; s_tready drops
// only when the queue is full. Reset clears the parser and queue pointers at
// once; there is no clearing pass. After a length error bytes are still taken
// and dropped until the next reset.
module websocket_frame_deframer import wsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // in_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // data_byte, opcode, fin, rsv1-3, masked, length
	output logic [1:0]         m_tuser,   // kind
	output logic               m_tlast    // frame_end
);

	qstat_t qstat;
	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;

	// Front: header parsing, unmask key selection and length countdown.
	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue decouples the parser from output back-pressure.
	wsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// Back: XOR unmasking and registered result transfer.
	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== design/wsd_front.sv =====
// Header parser: classifies each stream byte and queues the results.
module wsd_front import wsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  qstat_t      qstat,
	output logic        push,
	output entry_t      push_entry
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [7:0]       hdr0_q, hdr0_d;
	logic             mask_q, mask_d;
	logic [ACC_W-1:0] len_q, len_d;
	logic [3:0]       ext_q, ext_d;
	logic [31:0]      key_q, key_d;
	logic [2:0]       keyl_q, keyl_d;
	logic [LEN_W-1:0] rem_q, rem_d;
	logic             err_q, err_d;
	logic             hdone;
	logic             acc;

	assign in_ready = !qstat.full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		phase_d = phase_q;
		hdr0_d  = hdr0_q;
		mask_d  = mask_q;
		len_d   = len_q;
		ext_d   = ext_q;
		key_d   = key_q;
		keyl_d  = keyl_q;
		rem_d   = rem_q;
		err_d   = err_q;
		hdone   = 1'b0;
		push    = 1'b0;
		push_entry.kind = KIND_PAYLOAD;
		push_entry.raw  = 8'd0;
		push_entry.key  = 8'd0;
		push_entry.last = 1'b0;
		if (acc && !err_q) begin
			case (phase_q)
				PH_HDR0: begin
					hdr0_d  = in_byte;
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = in_byte[7];
					key_d  = 32'd0;
					len_d  = {57'd0, in_byte[6:0]};
					if (in_byte[6:0] == LEN_CODE16) begin
						len_d   = '0;
						ext_d   = EXT_BYTES16;
						phase_d = PH_EXT;
					end else if (in_byte[6:0] == LEN_CODE64) begin
						len_d   = '0;
						ext_d   = EXT_BYTES64;
						phase_d = PH_EXT;
					end else if (in_byte[7]) begin
						keyl_d  = KEY_BYTES;
						phase_d = PH_KEY;
					end else begin
						hdone = 1'b1;
					end
				end
				PH_EXT: begin
					len_d = {len_q[ACC_W-9:0], in_byte};
					ext_d = ext_q - 4'd1;
					if (ext_q == 4'd1) begin
						if (mask_q) begin
							keyl_d  = KEY_BYTES;
							phase_d = PH_KEY;
						end else begin
							hdone = 1'b1;
						end
					end
				end
				PH_KEY: begin
					key_d  = {key_q[23:0], in_byte};
					keyl_d = keyl_q - 3'd1;
					if (keyl_q == 3'd1) begin
						hdone = 1'b1;
					end
				end
				PH_DATA: begin
					push            = 1'b1;
					push_entry.kind = KIND_PAYLOAD;
					push_entry.raw  = in_byte;
					push_entry.key  = key_q[31:24];
					push_entry.last = (rem_q == LEN_W'(1));
					key_d = {key_q[23:0], key_q[31:24]};
					rem_d = rem_q - LEN_W'(1);
					if (rem_q == LEN_W'(1)) begin
						phase_d = PH_HDR0;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (hdone) begin
				if (len_d[ACC_W-1]) begin
					err_d           = 1'b1;
					phase_d         = PH_HDR0;
					push            = 1'b1;
					push_entry.kind = KIND_ERROR;
					push_entry.last = 1'b1;
				end else if (len_d == '0) begin
					phase_d         = PH_HDR0;
					push            = 1'b1;
					push_entry.kind = KIND_EMPTY;
					push_entry.last = 1'b1;
				end else begin
					rem_d   = len_d[LEN_W-1:0];
					phase_d = PH_DATA;
				end
			end
		end
		push_entry.hdr0   = hdr0_q;
		push_entry.masked = mask_d;
		push_entry.length = len_d[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			hdr0_q  <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			ext_q   <= '0;
			key_q   <= '0;
			keyl_q  <= '0;
			rem_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hdr0_q  <= hdr0_d;
			mask_q  <= mask_d;
			len_q   <= len_d;
			ext_q   <= ext_d;
			key_q   <= key_d;
			keyl_q  <= keyl_d;
			rem_q   <= rem_d;
			err_q   <= err_d;
		end
	end

endmodule

// ===== design/wsd_queue.sv =====
// Short queue of classified results between parser and output stage.
module wsd_queue import wsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t qstat
);

	entry_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/wsd_back.sv =====
// Output stage: unmasks payload bytes and holds the result until taken.
module wsd_back import wsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  entry_t             head,
	input  qstat_t             qstat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TDATA_W-1:0] out_data,
	output logic [1:0]         out_kind,
	output logic               out_last
);

	logic               vld_q;
	logic [TDATA_W-1:0] data_q;
	logic [1:0]         kind_q;
	logic               last_q;

	assign pop       = !qstat.empty && (!vld_q || out_ready);
	assign out_valid = vld_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	// data, opcode, fin, rsv1, rsv2, rsv3, masked, length from bit 0 up
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {head.length, head.masked, head.hdr0[4], head.hdr0[5],
				head.hdr0[6], head.hdr0[7], head.hdr0[3:0], head.raw ^ head.key};
			kind_q <= head.kind;
			last_q <= head.last;
		end
	end

endmodule

// ===== design/wsd_checker.sv =====
// Port-level checks of the deframer, bound to the top level.
`include "assert_macros.svh"

module wsd_checker import wsd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [1:0]         m_tuser,
	input logic               m_tlast
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`ASSERT_ALWAYS(a_kind_code, clk, arst_n, m_tvalid |-> (m_tuser == KIND_PAYLOAD || m_tuser == KIND_EMPTY || m_tuser == KIND_ERROR), "bad kind code")
	`ASSERT_ALWAYS(a_nonpay_last, clk, arst_n, (m_tvalid && m_tuser != KIND_PAYLOAD) |-> m_tlast, "empty or error result not frame end")
	`ASSERT_ALWAYS(a_nonpay_zero, clk, arst_n, (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'd0), "empty or error result carries data")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== verif/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for the WebSocket frame deframer: byte stream in, predicted results out.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;
	import wsd_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to fill the output queue
	localparam int STALL_LIMIT  = 1000;  // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES  = 135;
	localparam int MAX_REPORTS  = 10;

	// How a frame encodes its payload length.
	typedef enum logic [1:0] {
		ENC_7,
		ENC_16,
		ENC_64
	} len_enc_t;

	// Parser position within a frame.
	typedef enum logic [2:0] {
		P_HDR0,
		P_HDR1,
		P_EXT,
		P_KEY,
		P_DATA
	} parse_phase_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [3:0]       opcode;
		logic             fin, rsv1, rsv2, rsv3, masked;
		logic [LEN_W-1:0] length;
		logic             last;
	} frame_result_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;
	logic               m_tlast;

	websocket_frame_deframer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	logic [7:0]    stream_bytes[$];   // bytes waiting to be offered
	frame_result_t expected_out[$];   // predicted results, oldest first
	int            src_idle_pct  = 0;
	int            snk_stall_pct = 0;
	bit            long_hold     = 1'b0;
	int            hold_count    = 0;
	bit            in_fire       = 1'b0;
	int            mismatches    = 0;
	int            idle_cycles   = 0;
	int            bytes_queued  = 0;

	// Predictor state
	parse_phase_t     ph        = P_HDR0;
	logic [7:0]       hdr_byte  = '0;
	logic             mask_on   = 1'b0;
	logic [ACC_W-1:0] len_acc   = '0;
	logic [3:0]       ext_left  = '0;
	logic [31:0]      key_word  = '0;
	logic [2:0]       key_left  = '0;
	logic [LEN_W-1:0] remaining = '0;
	logic [1:0]       key_idx   = '0;
	logic             err_seen  = 1'b0;

	function automatic void post_result(kind_t k, logic [7:0] d, logic e);
		frame_result_t r;
		r.kind   = k;
		r.data   = d;
		r.opcode = hdr_byte[3:0];
		r.fin    = hdr_byte[7];
		r.rsv1   = hdr_byte[6];
		r.rsv2   = hdr_byte[5];
		r.rsv3   = hdr_byte[4];
		r.masked = mask_on;
		r.length = len_acc[LEN_W-1:0];
		r.last   = e;
		expected_out.push_back(r);
	endfunction

	// Whole header in: length error, empty frame, or start of payload.
	function automatic void header_complete();
		if (len_acc[ACC_W-1]) begin
			err_seen = 1'b1;
			ph = P_HDR0;
			post_result(KIND_ERROR, 8'h00, 1'b1);
		end else if (len_acc == '0) begin
			ph = P_HDR0;
			post_result(KIND_EMPTY, 8'h00, 1'b1);
		end else begin
			remaining = len_acc[LEN_W-1:0];
			key_idx = '0;
			ph = P_DATA;
		end
	endfunction

	function automatic void length_complete();
		if (mask_on) begin
			key_left = KEY_BYTES;
			ph = P_KEY;
		end else begin
			header_complete();
		end
	endfunction

	// One accepted stream byte through the parser.
	function automatic void deframe_byte(logic [7:0] b);
		logic [7:0] d;
		if (err_seen)
			return;
		case (ph)
			P_HDR0: begin
				hdr_byte = b;
				ph = P_HDR1;
			end
			P_HDR1: begin
				mask_on = b[7];
				key_word = '0;
				len_acc = '0;
				if (b[6:0] == LEN_CODE16) begin
					ext_left = EXT_BYTES16;
					ph = P_EXT;
				end else if (b[6:0] == LEN_CODE64) begin
					ext_left = EXT_BYTES64;
					ph = P_EXT;
				end else begin
					len_acc = {57'd0, b[6:0]};
					length_complete();
				end
			end
			P_EXT: begin
				len_acc = {len_acc[ACC_W-9:0], b};
				if (ext_left != 0)
					ext_left--;
				if (ext_left == 0)
					length_complete();
			end
			P_KEY: begin
				key_word = {key_word[23:0], b};
				if (key_left != 0)
					key_left--;
				if (key_left == 0)
					header_complete();
			end
			P_DATA: begin
				// key bytes are applied in arrival order, first one in the top byte
				d = mask_on ? (b ^ key_word[(3 - key_idx) * 8 +: 8]) : b;
				key_idx++;
				if (remaining != 0)
					remaining--;
				if (remaining == 0)
					ph = P_HDR0;
				post_result(KIND_PAYLOAD, d, remaining == 0);
			end
			default: ph = P_HDR0;
		endcase
	endfunction

	function automatic string fmt_result(frame_result_t r);
		return $sformatf("kind %0d data %02h op %h fin %b rsv %b%b%b mask %b len %0h end %b",
			r.kind, r.data, r.opcode, r.fin, r.rsv1, r.rsv2, r.rsv3, r.masked, r.length, r.last);
	endfunction

	// Queue one frame: header, extended length, key, then random payload.
	task automatic queue_frame(logic [7:0] b0, logic mask, logic [63:0] len, len_enc_t enc,
			logic [31:0] key);
		logic [6:0] code;
		int         n;
		code = (enc == ENC_7) ? len[6:0] : (enc == ENC_16) ? LEN_CODE16 : LEN_CODE64;
		stream_bytes.push_back(b0);
		stream_bytes.push_back({mask, code});
		bytes_queued += 2;
		n = (enc == ENC_16) ? 2 : (enc == ENC_64) ? 8 : 0;
		for (int i = n - 1; i >= 0; i--) begin
			stream_bytes.push_back(len[i * 8 +: 8]);
			bytes_queued++;
		end
		if (mask) begin
			for (int i = 3; i >= 0; i--)
				stream_bytes.push_back(key[i * 8 +: 8]);
			bytes_queued += 4;
		end
		if (!len[63]) begin
			for (int i = 0; i < int'(len[31:0]); i++)
				stream_bytes.push_back(8'($urandom()));
			bytes_queued += int'(len[31:0]);
		end
	endtask

	// Sender: new byte only once the previous offer has been transferred.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= stream_bytes.pop_front();
			end else begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom());
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off.
	always @(negedge clk) begin
		if (long_hold && hold_count < HOLD_CYCLES) begin
			hold_count++;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Monitor: predict on input transfers, check output transfers.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n) begin
			in_fire = s_tvalid && s_tready;
			if (in_fire)
				deframe_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				got.kind   = kind_t'(m_tuser);
				got.data   = m_tdata[7:0];
				got.opcode = m_tdata[11:8];
				got.fin    = m_tdata[12];
				got.rsv1   = m_tdata[13];
				got.rsv2   = m_tdata[14];
				got.rsv3   = m_tdata[15];
				got.masked = m_tdata[16];
				got.length = m_tdata[TDATA_W-1:17];
				got.last   = m_tlast;
				if (expected_out.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: %s", fmt_result(got));
				end else begin
					want = expected_out.pop_front();
					if (got.kind !== want.kind || got.data !== want.data
							|| got.opcode !== want.opcode || got.fin !== want.fin
							|| got.rsv1 !== want.rsv1 || got.rsv2 !== want.rsv2
							|| got.rsv3 !== want.rsv3 || got.masked !== want.masked
							|| got.length !== want.length || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch\n  expected %s\n  actual   %s",
								fmt_result(want), fmt_result(got));
					end
				end
			end
		end
	end

	// Watchdog: too long without any transfer means the block is stuck.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int         sel;
		logic       mask;
		logic [63:0] len;
		len_enc_t   enc;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			case (phase_no)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
				default: begin src_idle_pct = 37; snk_stall_pct = 37; end
			endcase
			bytes_queued = 0;
			if (phase_no == 0) begin
				queue_frame(8'h89, 1'b0, 64'd0, ENC_7, 32'h0);           // empty, no key
				queue_frame(8'h00, 1'b1, 64'd0, ENC_7, 32'hFFFF_FFFF);   // empty after a key
				queue_frame(8'hFF, 1'b1, 64'd1, ENC_7, 32'hA5C3_0F96);   // all first header byte bits set
				queue_frame(8'h82, 1'b0, 64'd2, ENC_16, 32'h0);          // non-minimal 16-bit
				queue_frame(8'h70, 1'b1, 64'd5, ENC_64, 32'h0102_0304);  // non-minimal 64-bit, key wraps
			end
			while (bytes_queued < PHASE_BYTES) begin
				sel  = $urandom_range(99);
				mask = 1'($urandom_range(1));
				if (sel < 65) begin
					len = 64'($urandom_range(12));
					enc = ENC_7;
				end else if (sel < 77) begin
					len = 64'($urandom_range(125));
					enc = ENC_7;
				end else if (sel < 89) begin
					len = ($urandom_range(9) == 0) ? 64'($urandom_range(400))
						: 64'($urandom_range(40));
					enc = ENC_16;
				end else begin
					len = 64'($urandom_range(24));
					enc = ENC_64;
				end
				queue_frame(8'($urandom()), mask, len, enc, $urandom());
			end
			if (phase_no == 0)
				long_hold = 1'b1;
			if (phase_no == 3) begin
				// top length bit set: error after the key, then everything is dropped
				queue_frame(8'($urandom()), 1'b1, {1'b1, 31'($urandom()), 32'($urandom())},
					ENC_64, $urandom());
				for (int i = 0; i < 12; i++)
					stream_bytes.push_back(8'($urandom()));
			end
			while (stream_bytes.size() != 0)
				@(posedge clk);
		end

		while (stream_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_out.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== websocket_frame_deframer.f =====
+incdir+design
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
design/wsd_checker.sv
verif/tb_websocket_frame_deframer.sv
